### rtl/core/mbd_pkg.sv
// Shared types, constants and pitch table for the melody byte decoder.
package mbd_pkg;

  localparam logic [15:0] BEAT_DIVIDEND = 16'd60000;
  localparam logic [15:0] DUR_MAX       = 16'hFFFF;
  localparam logic [4:0]  DIV_STEPS     = 5'd16;
  localparam logic [3:0]  NOTE_EXT      = 4'hE;
  localparam logic [3:0]  NOTE_REST     = 4'hF;
  localparam logic [7:0]  PITCH_ENTRIES = 8'd48;

  localparam logic [7:0] PITCH_TABLE [48] = '{
    8'd118, 8'd112, 8'd105, 8'd99, 8'd94, 8'd88, 8'd83, 8'd79, 8'd74, 8'd70, 8'd66, 8'd62,
    8'd59,  8'd55,  8'd52,  8'd49, 8'd46, 8'd44, 8'd41, 8'd39, 8'd37, 8'd35, 8'd33, 8'd31,
    8'd29,  8'd27,  8'd26,  8'd24, 8'd23, 8'd21, 8'd20, 8'd19, 8'd18, 8'd17, 8'd16, 8'd15,
    8'd14,  8'd13,  8'd12,  8'd12, 8'd11, 8'd10, 8'd10, 8'd9,  8'd8,  8'd8,  8'd7,  8'd7
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_FORM
  } state_e;

  typedef enum logic [1:0] {
    PH_OCTAVE,
    PH_BEAT,
    PH_NOTE,
    PH_EXT
  } phase_e;

  typedef struct packed {
    logic latch_byte;
    logic load_octave;
    logic div_start;
    logic load_beat;
    logic save_pending;
    logic calc_note;
    logic use_ext;
    logic mark_end;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic byte_zero;
    logic ext_marker;
    logic div_done;
    logic out_full;
  } sts_t;

  function automatic logic [7:0] pitch_lookup(input logic [5:0] idx);
    logic [7:0] val;
    val = 8'd0;
    if ({2'b00, idx} < PITCH_ENTRIES) begin
      val = PITCH_TABLE[idx];
    end
    return val;
  endfunction

endpackage

### rtl/core/mbd_if.sv
// Request and result channel interfaces of the melody byte decoder.
interface mbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] melody_byte;

  modport source (output valid, output melody_byte, input ready);
  modport sink   (input valid, input melody_byte, output ready);
endinterface

interface mbd_out_if;
  logic        valid;
  logic        ready;
  logic        tone_on;
  logic [7:0]  compare_value;
  logic [15:0] duration_ticks;
  logic        index_error;
  logic        melody_end;

  modport source (output valid, output tone_on, output compare_value,
                  output duration_ticks, output index_error, output melody_end,
                  input ready);
  modport sink   (input valid, input tone_on, input compare_value,
                  input duration_ticks, input index_error, input melody_end,
                  output ready);
endinterface

### rtl/core/mbd_ctrl.sv
// Controller: parse phase and per-request sequencing of the datapath.
module mbd_ctrl
  import mbd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_OCTAVE;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_byte = 1'b1;
          state_d          = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (phase_q)
          PH_OCTAVE: begin
            cmd_o.load_octave = 1'b1;
            phase_d           = PH_BEAT;
            state_d           = ST_IDLE;
          end
          PH_BEAT: begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end
          PH_NOTE: begin
            if (sts_i.byte_zero) begin
              cmd_o.calc_note = 1'b1;
              cmd_o.mark_end  = 1'b1;
              phase_d         = PH_OCTAVE;
              state_d         = ST_FORM;
            end else if (sts_i.ext_marker) begin
              cmd_o.save_pending = 1'b1;
              phase_d            = PH_EXT;
              state_d            = ST_IDLE;
            end else begin
              cmd_o.calc_note = 1'b1;
              state_d         = ST_FORM;
            end
          end
          PH_EXT: begin
            cmd_o.calc_note = 1'b1;
            cmd_o.use_ext   = 1'b1;
            phase_d         = PH_NOTE;
            state_d         = ST_FORM;
          end
        endcase
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.load_beat = 1'b1;
          phase_d         = PH_NOTE;
          state_d         = ST_IDLE;
        end
      end
      ST_FORM: begin
        if (!sts_i.out_full) begin
          cmd_o.load_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
    endcase
  end

endmodule

### rtl/core/mbd_datapath.sv
// Datapath: byte latch, tempo divider, duration and pitch logic, result register.
module mbd_datapath
  import mbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [7:0]  melody_byte_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic        tone_on_o,
  output logic [7:0]  compare_value_o,
  output logic [15:0] duration_ticks_o,
  output logic        index_error_o,
  output logic        melody_end_o
);

  logic [7:0]  byte_q;
  logic [3:0]  octave_q;
  logic [15:0] beat_q;
  logic [15:0] pending_q;

  // restoring divider, one quotient bit per cycle
  logic [15:0] num_q;
  logic [15:0] quo_q;
  logic [7:0]  rem_q;
  logic [4:0]  cnt_q;
  logic [8:0]  trial;
  logic        fits;

  // decoded note
  logic [15:0] dur_q;
  logic [7:0]  sum_q;
  logic        rest_q;
  logic        end_q;

  logic        out_valid_q;
  logic        tone_q;
  logic [7:0]  cmp_q;
  logic [15:0] dur_out_q;
  logic        err_q;
  logic        end_out_q;

  logic [15:0] shifted;
  logic [16:0] dotted;
  logic [15:0] dur_calc;
  logic [3:0]  note_oct;
  logic [3:0]  note_nib;
  logic [7:0]  sum_calc;
  logic        idx_bad;
  logic        play;
  logic [7:0]  idx_m1;

  assign trial = {rem_q, num_q[15]};
  assign fits  = trial >= {1'b0, byte_q};

  assign shifted = beat_q >> byte_q[7:5];
  assign dotted  = {1'b0, shifted} + {2'b00, shifted[15:1]};
  assign dur_calc = !byte_q[4] ? shifted : (dotted[16] ? DUR_MAX : dotted[15:0]);

  assign note_oct = cmd_i.use_ext ? byte_q[7:4] : octave_q;
  assign note_nib = byte_q[3:0];
  assign sum_calc = {1'b0, note_oct, 3'b000} + {2'b00, note_oct, 2'b00} + {4'b0000, note_nib};

  assign idx_bad = (sum_q == 8'd0) || (sum_q > PITCH_ENTRIES);
  assign play    = !end_q && !rest_q && !idx_bad;
  assign idx_m1  = sum_q - 8'd1;

  assign sts_o.byte_zero  = byte_q == 8'd0;
  assign sts_o.ext_marker = byte_q[3:0] == NOTE_EXT;
  assign sts_o.div_done   = cnt_q == 5'd0;
  assign sts_o.out_full   = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octave_q  <= '0;
      beat_q    <= '0;
      pending_q <= '0;
      cnt_q     <= '0;
    end else begin
      if (cmd_i.load_octave) begin
        octave_q <= byte_q[3:0];
      end
      if (cmd_i.load_beat) begin
        beat_q <= (byte_q == 8'd0) ? DUR_MAX : quo_q;
      end
      if (cmd_i.save_pending) begin
        pending_q <= dur_calc;
      end
      if (cmd_i.div_start) begin
        cnt_q <= DIV_STEPS;
      end else if (cnt_q != 5'd0) begin
        cnt_q <= cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_byte) begin
      byte_q <= melody_byte_i;
    end
    if (cmd_i.div_start) begin
      num_q <= BEAT_DIVIDEND;
      quo_q <= '0;
      rem_q <= '0;
    end else if (cnt_q != 5'd0) begin
      num_q <= {num_q[14:0], 1'b0};
      quo_q <= {quo_q[14:0], fits};
      rem_q <= fits ? 8'(trial - {1'b0, byte_q}) : trial[7:0];
    end
    if (cmd_i.calc_note) begin
      dur_q  <= cmd_i.mark_end ? 16'd0 : (cmd_i.use_ext ? pending_q : dur_calc);
      sum_q  <= sum_calc;
      rest_q <= note_nib == NOTE_REST;
      end_q  <= cmd_i.mark_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      tone_q    <= play;
      cmp_q     <= play ? pitch_lookup(idx_m1[5:0]) : 8'd0;
      dur_out_q <= dur_q;
      err_q     <= !end_q && !rest_q && idx_bad;
      end_out_q <= end_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign tone_on_o        = tone_q;
  assign compare_value_o  = cmp_q;
  assign duration_ticks_o = dur_out_q;
  assign index_error_o    = err_q;
  assign melody_end_o     = end_out_q;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_result |-> !(out_valid_q && !out_ready_i))
    else $error("result loaded over an untaken result");

  a_result_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_result |=> out_valid_q)
    else $error("loaded result not presented");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DIV_STEPS)
    else $error("divider step count out of range");

  a_end_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && end_out_q) |-> (!tone_q && !err_q && dur_out_q == 16'd0))
    else $error("end result carries note data");
`endif

endmodule

### rtl/core/melody_byte_decoder.sv
// Top level of the melody byte decoder: channels, controller and datapath.
//
// Usage: coded melody bytes enter on req_i, one byte per request; note
// commands leave on rsp_o. Both channels use valid/ready, a transfer
// happening on a clock edge with both high.
// Stream layout: an octave header byte, a tempo header byte, then note
// bytes; a note byte with low nibble 0xE is followed by an extension byte
// carrying octave and note. A zero note byte ends the melody, yields an
// end result and the decoder expects a new header.
// Sequencing: header and extension-marker bytes give no result. The tempo
// byte runs a restoring divider, one quotient bit a cycle, before the next
// byte is accepted. Other note bytes pass the decode and form steps; the
// result is registered onto rsp_o in the form step.
// The result register decouples the channels: a new byte is accepted while
// a result still waits; the decoder only holds in its final step when the
// previous result has not been taken yet.
// Reset (rst_ni low, asynchronous) clears the parse phase to expect the
// octave header and drops any pending result; no clearing pass is needed.
module melody_byte_decoder
  import mbd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  mbd_in_if.sink   req_i,
  mbd_out_if.source rsp_o
);

  cmd_t cmd;
  sts_t sts;

  // phase tracking and sequencing
  mbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic, tables and the result register
  mbd_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .melody_byte_i    (req_i.melody_byte),
    .out_ready_i      (rsp_o.ready),
    .out_valid_o      (rsp_o.valid),
    .tone_on_o        (rsp_o.tone_on),
    .compare_value_o  (rsp_o.compare_value),
    .duration_ticks_o (rsp_o.duration_ticks),
    .index_error_o    (rsp_o.index_error),
    .melody_end_o     (rsp_o.melody_end)
  );

endmodule

### tb/tb_melody_byte_decoder.sv
// Self-checking testbench for the melody byte decoder: directed table, then random melodies.
module tb_melody_byte_decoder;
  import mbd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Run shape
  localparam int TOTAL_ITEMS  = 1650;
  localparam int CALM_ITEMS   = 150;     // tail of the run with no idling
  localparam int HOLD_AT      = 400;     // requests sent before the long sink hold-off
  localparam int HOLD_CYCLES  = 300;
  localparam int PAUSE_AT     = 1000;    // requests sent before the drain pause
  localparam int TAIL_CYCLES  = 40;      // tempo divide is the longest path
  localparam int LIMIT_CYCLES = 400000;

  // One note command as it leaves the decoder.
  typedef struct packed {
    logic        tone_on;
    logic [7:0]  compare_value;
    logic [15:0] duration_ticks;
    logic        index_error;
    logic        melody_end;
  } note_cmd_t;

  // Directed row: byte to send, and a hand-written result where one is obvious.
  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    note_cmd_t  want;
  } stim_row_t;

  localparam note_cmd_t NO_CMD  = '0;
  localparam note_cmd_t END_CMD = '{1'b0, 8'd0, 16'd0, 1'b0, 1'b1};

  // Timer compare values, indexed by octave*12 + note - 1.
  localparam logic [7:0] TONE_CMP [48] = '{
    8'd118, 8'd112, 8'd105, 8'd99, 8'd94, 8'd88, 8'd83, 8'd79, 8'd74, 8'd70, 8'd66, 8'd62,
    8'd59,  8'd55,  8'd52,  8'd49, 8'd46, 8'd44, 8'd41, 8'd39, 8'd37, 8'd35, 8'd33, 8'd31,
    8'd29,  8'd27,  8'd26,  8'd24, 8'd23, 8'd21, 8'd20, 8'd19, 8'd18, 8'd17, 8'd16, 8'd15,
    8'd14,  8'd13,  8'd12,  8'd12, 8'd11, 8'd10, 8'd10, 8'd9,  8'd8,  8'd8,  8'd7,  8'd7
  };

  // Directed stream: three melodies covering saturation, extension, rest, index errors, end.
  localparam stim_row_t DIRECTED [24] = '{
    '{8'h0F, 1'b0, NO_CMD},                                   // octave 15
    '{8'h00, 1'b0, NO_CMD},                                   // zero divisor -> 65535
    '{8'h01, 1'b1, '{1'b0, 8'd0, 16'd65535, 1'b1, 1'b0}},     // index far above table
    '{8'h1F, 1'b1, '{1'b0, 8'd0, 16'd65535, 1'b0, 1'b0}},     // dotted rest, saturates
    '{8'hEE, 1'b0, NO_CMD},                                   // ext marker, shift 7
    '{8'h00, 1'b1, '{1'b0, 8'd0, 16'd511, 1'b1, 1'b0}},       // zero ext byte is data
    '{8'hFE, 1'b0, NO_CMD},                                   // dotted ext marker
    '{8'h3C, 1'b1, '{1'b1, 8'd7, 16'd766, 1'b0, 1'b0}},       // last table entry
    '{8'h0E, 1'b0, NO_CMD},
    '{8'h01, 1'b1, '{1'b1, 8'd118, 16'd65535, 1'b0, 1'b0}},   // first table entry
    '{8'h00, 1'b1, END_CMD},
    '{8'h03, 1'b0, NO_CMD},                                   // octave 3
    '{8'hFF, 1'b0, NO_CMD},                                   // largest divisor
    '{8'h0D, 1'b0, NO_CMD},                                   // index 48, just past table
    '{8'h2C, 1'b0, NO_CMD},
    '{8'h0E, 1'b0, NO_CMD},
    '{8'hFF, 1'b0, NO_CMD},                                   // rest via extension
    '{8'h00, 1'b1, END_CMD},
    '{8'h50, 1'b0, NO_CMD},                                   // octave 0, high nibble ignored
    '{8'h01, 1'b0, NO_CMD},                                   // beat 60000
    '{8'h10, 1'b1, '{1'b0, 8'd0, 16'd65535, 1'b1, 1'b0}},     // index -1, dotted saturates
    '{8'h9F, 1'b0, NO_CMD},
    '{8'hA5, 1'b0, NO_CMD},
    '{8'h00, 1'b1, END_CMD}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  mbd_in_if  req_if ();
  mbd_out_if rsp_if ();

  melody_byte_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow decoder state
  phase_e      mel_phase   = PH_OCTAVE;
  logic [3:0]  mel_octave  = '0;
  logic [15:0] mel_beat    = '0;
  logic [15:0] mel_pending = '0;

  note_cmd_t due_cmds [$];        // commands owed by the decoder, oldest first
  int        mismatches  = 0;
  int        items_sent  = 0;
  int        notes_left  = 0;     // notes still to go in the current random melody
  int        tx_idle_pct = 0;
  bit        calm        = 1'b0;  // no idling on either side
  int        cycle_count = 0;

  // Pitch lookup with rest and out-of-table handling.
  function automatic note_cmd_t pitch_cmd(input logic [3:0] octave, input logic [3:0] nib,
                                          input logic [15:0] dur);
    note_cmd_t c;
    int        idx;
    c = '0;
    c.duration_ticks = dur;
    idx = int'(octave) * 12 + int'(nib) - 1;
    if (nib != NOTE_REST) begin
      if (idx < 0 || idx > 47) begin
        c.index_error = 1'b1;
      end else begin
        c.tone_on       = 1'b1;
        c.compare_value = TONE_CMP[idx];
      end
    end
    return c;
  endfunction

  // Advance the shadow state by one accepted byte; returns 1 when a command is owed.
  function automatic bit decode_melody_byte(input logic [7:0] b, output note_cmd_t cmd);
    int dur;
    bit has_cmd;
    cmd     = '0;
    has_cmd = 1'b0;
    case (mel_phase)
      PH_BEAT: begin
        mel_beat  = (b == 8'h00) ? 16'hFFFF : 16'(60000 / int'(b));
        mel_phase = PH_NOTE;
      end
      PH_NOTE: begin
        if (b == 8'h00) begin
          cmd.melody_end = 1'b1;
          mel_phase      = PH_OCTAVE;
          has_cmd        = 1'b1;
        end else begin
          dur = int'(mel_beat) >> b[7:5];
          if (b[4]) begin
            dur = dur * 3 / 2;
            if (dur > 65535) dur = 65535;
          end
          if (b[3:0] == NOTE_EXT) begin
            mel_pending = 16'(dur);
            mel_phase   = PH_EXT;
          end else begin
            cmd     = pitch_cmd(mel_octave, b[3:0], 16'(dur));
            has_cmd = 1'b1;
          end
        end
      end
      PH_EXT: begin
        cmd       = pitch_cmd(b[7:4], b[3:0], mel_pending);
        mel_phase = PH_NOTE;
        has_cmd   = 1'b1;
      end
      default: begin
        mel_octave = b[3:0];
        mel_phase  = PH_BEAT;
      end
    endcase
    return has_cmd;
  endfunction

  // Mostly well-formed melodies following the shadow phase, with a little raw noise.
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 19) != 0) begin
      case (mel_phase)
        PH_OCTAVE: begin
          notes_left = $urandom_range(1, 40);
          if ($urandom_range(0, 3) != 0) b[3:0] = 4'($urandom_range(0, 4));
        end
        PH_BEAT: begin
          if ($urandom_range(0, 15) == 0) b = 8'h00;
        end
        PH_NOTE: begin
          if (notes_left == 0) begin
            b = 8'h00;
          end else begin
            notes_left--;
            if ($urandom_range(0, 4) == 0) b[3:0] = NOTE_EXT;
            if (b == 8'h00) b = 8'h01;
          end
        end
        default: begin
          if ($urandom_range(0, 3) != 0) b[7:4] = 4'($urandom_range(0, 4));
        end
      endcase
    end
    return b;
  endfunction

  // Offer one request; called at a falling edge, returns at a falling edge.
  task automatic offer_byte(input logic [7:0] b, input logic typed, input note_cmd_t want);
    note_cmd_t cmd;
    int        gap;
    req_if.valid       <= 1'b1;
    req_if.melody_byte <= b;
    do @(posedge clk_i); while (!req_if.ready);
    if (decode_melody_byte(b, cmd)) due_cmds.push_back(typed ? want : cmd);
    items_sent++;
    calm = (items_sent >= TOTAL_ITEMS - CALM_ITEMS);
    if (items_sent % 64 == 0) tx_idle_pct = $urandom_range(0, 3) * 10;
    @(negedge clk_i);
    if (!calm && $urandom_range(1, 100) <= tx_idle_pct) begin
      gap = $urandom_range(1, 8);
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Result checker: every accepted command against the oldest one owed.
  always @(posedge clk_i) begin
    note_cmd_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (due_cmds.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none actual tone %0d cmp %0d dur %0d err %0d end %0d",
                 $time, rsp_if.tone_on, rsp_if.compare_value, rsp_if.duration_ticks,
                 rsp_if.index_error, rsp_if.melody_end);
      end else begin
        want = due_cmds.pop_front();
        check_field("tone_on",        want.tone_on,        rsp_if.tone_on);
        check_field("compare_value",  want.compare_value,  rsp_if.compare_value);
        check_field("duration_ticks", want.duration_ticks, rsp_if.duration_ticks);
        check_field("index_error",    want.index_error,    rsp_if.index_error);
        check_field("melody_end",     want.melody_end,     rsp_if.melody_end);
      end
    end
  end

  // Sink side: random idle bursts, one long hold-off mid run, none in the calm tail.
  initial begin : sink_side
    int idle_left   = 0;
    int rx_idle_pct = 0;
    int tick        = 0;
    int hold_left   = 0;
    bit held        = 1'b0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      tick++;
      if (tick % 64 == 0) rx_idle_pct = $urandom_range(0, 3) * 10;
      if (!held && items_sent >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        rsp_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(1, 100) <= rx_idle_pct) begin
        idle_left = $urandom_range(1, 8) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Source side and end of run
  initial begin : source_side
    bit paused = 1'b0;
    req_if.valid       = 1'b0;
    req_if.melody_byte = 8'h00;
    rst_ni             = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIRECTED[i]) begin
      offer_byte(DIRECTED[i].b, DIRECTED[i].typed, DIRECTED[i].want);
    end

    while (items_sent < TOTAL_ITEMS) begin
      if (!paused && items_sent >= PAUSE_AT) begin
        // drain pause: nothing offered until every command has come out
        paused = 1'b1;
        req_if.valid <= 1'b0;
        while (due_cmds.size() != 0) @(negedge clk_i);
        @(negedge clk_i);
      end
      offer_byte(pick_byte(), 1'b0, NO_CMD);
    end
    req_if.valid <= 1'b0;

    while (due_cmds.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && due_cmds.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
